// ----- src/argb_planar_rle_decoder_unit_assert.svh -----
// Assertion macros for the planar RLE decoder.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef ARGB_PLANAR_RLE_DECODER_UNIT_ASSERT_SVH
`define ARGB_PLANAR_RLE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ARPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpd: same-cycle check failed");
`define ARPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpd: next-cycle check failed");
`else
`define ARPD_ASSERT_IMPL(lbl, ante, cons)
`define ARPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/arpd_pkg.sv -----
// Shared types and constants for the planar RLE decoder.
// No dependencies; imported by every module of the block.
package arpd_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 16384;
    localparam int unsigned PIXEL_COUNT_W  = 15;

    localparam logic [14:0] PIXEL_COUNT_RST = 15'd256;
    localparam logic [7:0]  RUN_MARK        = 8'h80;
    localparam logic [7:0]  RUN_BIAS        = 8'd3;
    localparam logic [2:0]  PAD_BYTES       = 3'd4;

    localparam logic [1:0]  REG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0]  REG_HAS_ALPHA   = 2'd1;
    localparam logic [1:0]  REG_SKIP_HEADER = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERRUN,
        ST_SHORT,
        ST_EXCESS
    } arpd_status_t;

    typedef enum logic [1:0] {
        CH_ALPHA,
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } arpd_channel_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_PAD,
        PH_HDR,
        PH_RUN,
        PH_LIT,
        PH_TRAIL,
        PH_DISCARD
    } arpd_phase_t;

    typedef struct packed {
        logic [14:0] pixel_count;
        logic        has_alpha;
        logic        skip_header;
    } arpd_cfg_t;

    typedef struct packed {
        logic [7:0]    sample_value;
        logic [7:0]    repeat_count;
        arpd_channel_t channel;
        logic          finished;
        arpd_status_t  status;
    } arpd_result_t;

endpackage

// ----- src/arpd_cfg.sv -----
// APB-style register file for the planar RLE decoder.
// Depends on arpd_pkg for the register map and the config struct.
module arpd_cfg
    import arpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output arpd_cfg_t   cfg
);

    arpd_cfg_t  cfg_reg;
    arpd_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PIXEL_COUNT: cfg_next.pixel_count = pwdata[14:0];
                REG_HAS_ALPHA:   cfg_next.has_alpha   = pwdata[0];
                REG_SKIP_HEADER: cfg_next.skip_header = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PIXEL_COUNT: prdata = {17'd0, cfg_reg.pixel_count};
            REG_HAS_ALPHA:   prdata = {31'd0, cfg_reg.has_alpha};
            REG_SKIP_HEADER: prdata = {31'd0, cfg_reg.skip_header};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_count <= PIXEL_COUNT_RST;
            cfg_reg.has_alpha   <= 1'b0;
            cfg_reg.skip_header <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/arpd_decode.sv -----
// Input register and per-byte decode step of the planar RLE decoder.
// Depends on arpd_pkg for phase, channel, status and result types.
module arpd_decode
    import arpd_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  arpd_cfg_t    cfg,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         res_room,
    output logic         res_valid,
    output arpd_result_t res
);

    localparam int CW   = $clog2(MAX_PIXELS + 1);
    localparam int EW   = (CW > PIXEL_COUNT_W) ? CW : PIXEL_COUNT_W;
    localparam int SUMW = ((CW > 8) ? CW : 8) + 1;

    // input stage
    logic          in_vld_reg;
    logic          in_vld_next;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          fire;

    // stream state
    arpd_phase_t   phase_reg, phase_next;
    logic [2:0]    pad_reg, pad_next;
    arpd_channel_t ch_reg, ch_next;
    logic [CW-1:0] sd_reg, sd_next;
    logic [7:0]    lit_reg, lit_next;
    logic [7:0]    run_reg, run_next;
    logic          trail_reg, trail_next;

    // state as seen by this byte (after a stream start is applied)
    arpd_phase_t   ph;
    logic [2:0]    pad;
    arpd_channel_t ch;
    logic [CW-1:0] sd;
    logic [7:0]    lit;
    logic [7:0]    run;
    logic          trail;

    logic [EW-1:0]   pc_ext;
    logic [EW-1:0]   max_ext;
    logic [EW-1:0]   eff_w;
    logic [SUMW-1:0] eff;
    logic [7:0]      hdr_num;
    logic [SUMW-1:0] hdr_sum;
    logic [7:0]      lit_dec;
    logic [7:0]      rep;
    logic            pkt_done;
    logic [SUMW-1:0] sd_new;
    logic            chan_full;
    logic            blue_done;

    logic            out_c;
    logic            fail_c;
    logic            fail_fin;
    arpd_status_t    fail_st;
    arpd_result_t    res_c;

    assign s_tready = !in_vld_reg || res_room;
    assign fire     = in_vld_reg && res_room;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
    end

    // clamp the live pixel count to 1..MAX_PIXELS
    assign pc_ext  = EW'(cfg.pixel_count);
    assign max_ext = EW'(MAX_PIXELS);
    assign eff_w   = (pc_ext == '0) ? EW'(1) : ((pc_ext > max_ext) ? max_ext : pc_ext);
    assign eff     = SUMW'(eff_w);

    always_comb
    begin
        ph    = phase_reg;
        pad   = pad_reg;
        ch    = ch_reg;
        sd    = sd_reg;
        lit   = lit_reg;
        run   = run_reg;
        trail = trail_reg;
        if (phase_reg == PH_START)
        begin
            pad   = cfg.skip_header ? PAD_BYTES : 3'd0;
            ch    = cfg.has_alpha ? CH_ALPHA : CH_RED;
            sd    = '0;
            lit   = 8'd0;
            run   = 8'd0;
            trail = 1'b0;
            ph    = cfg.skip_header ? PH_PAD : PH_HDR;
        end
    end

    assign hdr_num   = (in_byte_reg >= RUN_MARK) ? (in_byte_reg - RUN_MARK + RUN_BIAS)
                                                 : (in_byte_reg + 8'd1);
    assign hdr_sum   = SUMW'(sd) + SUMW'(hdr_num);
    assign lit_dec   = (lit != 8'd0) ? (lit - 8'd1) : 8'd0;
    assign rep       = (ph == PH_RUN) ? run : 8'd1;
    assign pkt_done  = (ph == PH_RUN) || (lit_dec == 8'd0);
    assign sd_new    = SUMW'(sd) + SUMW'(rep);
    assign chan_full = (sd_new >= eff);
    assign blue_done = pkt_done && (ch == CH_BLUE) && chan_full;

    always_comb
    begin
        phase_next = ph;
        pad_next   = pad;
        ch_next    = ch;
        sd_next    = sd;
        lit_next   = lit;
        run_next   = run;
        trail_next = trail;
        out_c      = 1'b0;
        fail_c     = 1'b0;
        fail_fin   = in_last_reg;
        fail_st    = ST_OK;
        res_c.sample_value = in_byte_reg;
        res_c.repeat_count = rep;
        res_c.channel      = ch;
        res_c.finished     = in_last_reg;
        res_c.status       = ST_OK;

        unique case (ph)
            PH_PAD:
            begin
                pad_next   = (pad != 3'd0) ? (pad - 3'd1) : 3'd0;
                phase_next = (pad_next == 3'd0) ? PH_HDR : PH_PAD;
                if (in_last_reg)
                begin
                    fail_c   = 1'b1;
                    fail_st  = ST_SHORT;
                    fail_fin = 1'b1;
                end
            end
            PH_HDR:
            begin
                // overrun wins over a short stream
                if (hdr_sum > eff)
                begin
                    fail_c  = 1'b1;
                    fail_st = ST_OVERRUN;
                end
                else if (in_last_reg)
                begin
                    fail_c   = 1'b1;
                    fail_st  = ST_SHORT;
                    fail_fin = 1'b1;
                end
                else if (in_byte_reg >= RUN_MARK)
                begin
                    run_next   = hdr_num;
                    phase_next = PH_RUN;
                end
                else
                begin
                    lit_next   = hdr_num;
                    phase_next = PH_LIT;
                end
            end
            PH_RUN, PH_LIT:
            begin
                if (ph == PH_RUN)
                    run_next = 8'd0;
                else
                    lit_next = lit_dec;
                sd_next = CW'(sd_new);
                if (in_last_reg && !blue_done)
                begin
                    fail_c   = 1'b1;
                    fail_st  = ST_SHORT;
                    fail_fin = 1'b1;
                end
                else
                begin
                    out_c = 1'b1;
                    if (pkt_done)
                    begin
                        phase_next = PH_HDR;
                        if (chan_full)
                        begin
                            if (ch == CH_BLUE)
                                phase_next = PH_TRAIL;
                            else
                            begin
                                ch_next = arpd_channel_t'(ch + 2'd1);
                                sd_next = '0;
                            end
                        end
                    end
                    if (in_last_reg)
                        phase_next = PH_START;
                end
            end
            PH_TRAIL:
            begin
                if (trail)
                begin
                    fail_c  = 1'b1;
                    fail_st = ST_EXCESS;
                end
                else if (in_last_reg)
                begin
                    out_c              = 1'b1;
                    phase_next         = PH_START;
                    res_c.sample_value = 8'd0;
                    res_c.repeat_count = 8'd0;
                    res_c.finished     = 1'b1;
                end
                else
                    trail_next = 1'b1;
            end
            default:
            begin
                // discard until the stream ends
                if (in_last_reg)
                    phase_next = PH_START;
            end
        endcase

        if (fail_c)
        begin
            out_c              = 1'b1;
            phase_next         = fail_fin ? PH_START : PH_DISCARD;
            res_c.sample_value = 8'd0;
            res_c.repeat_count = 8'd0;
            res_c.channel      = ch;
            res_c.finished     = 1'b1;
            res_c.status       = fail_st;
        end
    end

    assign res_valid = fire && out_c;
    assign res       = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            phase_reg  <= PH_START;
            pad_reg    <= 3'd0;
            ch_reg     <= CH_RED;
            sd_reg     <= '0;
            lit_reg    <= 8'd0;
            run_reg    <= 8'd0;
            trail_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                pad_reg   <= pad_next;
                ch_reg    <= ch_next;
                sd_reg    <= sd_next;
                lit_reg   <= lit_next;
                run_reg   <= run_next;
                trail_reg <= trail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// ----- src/arpd_out_q.sv -----
// Two-entry result queue that decouples the decoder from output stalls.
// Depends on arpd_pkg for the result struct.
module arpd_out_q
    import arpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  arpd_result_t push_data,
    output logic         room,
    output logic         m_tvalid,
    input  logic         m_tready,
    output arpd_result_t head
);

    arpd_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         pop;

    assign room     = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- src/argb_planar_rle_decoder_unit.sv -----
// Top level of the planar ARGB/RGB run-length decoder.
// Depends on arpd_pkg, arpd_cfg, arpd_decode, arpd_out_q and the assertion header.

// Decodes a packed run-length stream one byte per beat, channel by channel
// (alpha when enabled, then red, green, blue), and emits one beat per data
// byte with its value, repeat count and channel, or a status-only beat that
// ends the stream. The block takes one byte every cycle while the queue has
// room: each byte is registered, decoded against small counters and written
// into a two-entry result queue, so a result reaches the output through the
// input register and the queue, and input keeps flowing while one result
// waits downstream. Input stalls only when both queue entries are occupied.
// Configuration registers: 0x0 pixel_count, 0x4 has_alpha, 0x8 skip_header;
// has_alpha and skip_header take effect at the next stream start, pixel_count
// at once.
`include "argb_planar_rle_decoder_unit_assert.svh"

module argb_planar_rle_decoder_unit
    import arpd_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packed_byte
    input  logic        s_tlast,   // final_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] sample_value, [15:8] repeat_count
    output logic [3:0]  m_tuser,   // [1:0] channel, [3:2] status
    output logic        m_tlast,   // finished
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    arpd_cfg_t    cfg;
    logic         res_room;
    logic         res_valid;
    arpd_result_t res;
    arpd_result_t head;

    arpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arpd_decode #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .res_room  (res_room),
        .res_valid (res_valid),
        .res       (res)
    );

    arpd_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (res_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (head)
    );

    assign m_tdata = {head.repeat_count, head.sample_value};
    assign m_tuser = {head.status, head.channel};
    assign m_tlast = head.finished;

    `ARPD_ASSERT_IMPL(a_stall_means_full, !s_tready, m_tvalid)
    `ARPD_ASSERT_IMPL(a_error_ends_stream, m_tvalid && (m_tuser[3:2] != ST_OK), m_tlast)
    `ARPD_ASSERT_IMPL(a_status_only_ends_stream, m_tvalid && (m_tdata[15:8] == 8'd0), m_tlast)
    `ARPD_ASSERT_NEXT(a_push_shows_next, res_valid && !m_tvalid, m_tvalid)

endmodule
